// ===== hw/rtl/kst_pkg.sv =====
// Shared types and constants for the scan-code key tracker.
package kst_pkg;

  localparam logic [1:0] FUNC_SCAN  = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;

  localparam int unsigned MAP_DEPTH  = 256;
  localparam int unsigned CHUNK_W    = 8;
  localparam int unsigned CHUNK_CNT  = MAP_DEPTH / CHUNK_W;
  localparam int unsigned CHUNK_IW   = $clog2(CHUNK_CNT);
  localparam int unsigned POS_W      = $clog2(CHUNK_W);

  // Keys that carry a name, one bit per key index (bit n = key n).
  localparam logic [MAP_DEPTH-1:0] NAMED_MASK = {
    32'h0000_0000, 32'h000F_AB80, 32'h01A0_0000, 32'h3000_0000,
    32'h0000_0000, 32'h01DF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE
  };

  typedef struct packed {
    logic capture;
    logic update;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } kst_cmd_t;

  typedef struct packed {
    logic found;
    logic last;
  } kst_sts_t;

endpackage

// ===== hw/rtl/keyboard_scan_code_key_tracker.sv =====
// Top level of the scan-code set 1 key tracker.
// Takes one transaction at a time: capture, key-map update, then a search of the map for the
// lowest pressed named key, eight keys a cycle, stopping at the first hit or after the last of
// its 32 windows. A finished result sits in an output register, so the next transaction is
// accepted while it waits to be taken. Key map and prefix flag clear on reset; no clearing pass
// is needed.
module keyboard_scan_code_key_tracker
  import kst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [7:0] in_scan_code,
  input  logic [7:0] in_query_key,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_key_is_down,
  output logic [7:0] out_first_down_key,
  output logic       out_any_down
);

  kst_cmd_t cmd;
  kst_sts_t sts;

  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kst_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_scan_code       (in_scan_code),
    .in_query_key       (in_query_key),
    .out_key_is_down    (out_key_is_down),
    .out_first_down_key (out_first_down_key),
    .out_any_down       (out_any_down)
  );

endmodule

// ===== hw/rtl/kst_ctrl.sv =====
// Controller state machine: sequences capture, map update, search and output load.
module kst_ctrl
  import kst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  kst_sts_t sts,
  output kst_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_HOLD   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update     = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found || sts.last) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        // wait here until the output register has room
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/kst_datapath.sv =====
// Datapath: key map, prefix flag, chunked lowest-named-key search and result register.
module kst_datapath
  import kst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  kst_cmd_t   cmd,
  output kst_sts_t   sts,
  input  logic [1:0] in_func,
  input  logic [7:0] in_scan_code,
  input  logic [7:0] in_query_key,
  output logic       out_key_is_down,
  output logic [7:0] out_first_down_key,
  output logic       out_any_down
);

  logic [MAP_DEPTH-1:0] map_r, map_nxt;
  logic                 prefix_r, prefix_nxt;
  logic [1:0]           func_r;
  logic [7:0]           code_r;
  logic [7:0]           query_r;
  logic [CHUNK_IW-1:0]  cnt_r;
  logic [7:0]           first_r;
  logic [CHUNK_W-1:0]   chunk;
  logic [POS_W-1:0]     pos;
  logic                 down_r;
  logic [7:0]           first_out_r;

  always_comb begin
    map_nxt    = map_r;
    prefix_nxt = prefix_r;
    if (cmd.update) begin
      priority if (func_r == FUNC_SCAN) begin
        if (code_r == PREFIX_BYTE) begin
          prefix_nxt = 1'b1;
        end else begin
          map_nxt[{prefix_r, code_r[6:0]}] = ~code_r[7];
          prefix_nxt = 1'b0;
        end
      end else if (func_r == FUNC_CLEAR) begin
        map_nxt = '0;
      end else begin
        map_nxt = map_r;
      end
    end
  end

  // current search window, masked to named keys
  assign chunk = map_r[{cnt_r, POS_W'(0)} +: CHUNK_W]
               & NAMED_MASK[{cnt_r, POS_W'(0)} +: CHUNK_W];

  always_comb begin
    pos = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (chunk[i]) pos = POS_W'(i);
    end
  end

  assign sts.found = |chunk;
  assign sts.last  = (cnt_r == CHUNK_IW'(CHUNK_CNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r    <= '0;
      prefix_r <= 1'b0;
    end else begin
      map_r    <= map_nxt;
      prefix_r <= prefix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      code_r  <= in_scan_code;
      query_r <= in_query_key;
    end
    if (cmd.scan_start) begin
      cnt_r   <= '0;
      first_r <= '0;
    end else if (cmd.scan_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (sts.found) first_r <= {cnt_r, pos};
    end
    if (cmd.load_out) begin
      down_r      <= map_r[query_r];
      first_out_r <= first_r;
    end
  end

  assign out_key_is_down    = down_r;
  assign out_first_down_key = first_out_r;
  assign out_any_down       = |first_out_r;

endmodule

// ===== hw/rtl/kst_checker.sv =====
// Port-level checker for the key tracker, bound to the top level.
module kst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_key_is_down,
  input logic [7:0] out_first_down_key,
  input logic       out_any_down
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_first_down_key)
      && $stable(out_key_is_down) && $stable(out_any_down))
    else $error("stalled result changed");

  a_any_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_any_down == (out_first_down_key != 8'd0)))
    else $error("any_down disagrees with first_down_key");

  a_named_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_first_down_key <= 8'hD3))
    else $error("first_down_key beyond named range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind keyboard_scan_code_key_tracker kst_checker u_kst_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_key_is_down    (out_key_is_down),
  .out_first_down_key (out_first_down_key),
  .out_any_down       (out_any_down)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the scan-code set 1 key tracker.
module testbench
  import kst_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 830;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [1:0] func;
    logic [7:0] scan_code;
    logic [7:0] query_key;
    bit         wait_drain;
    bit         calm;
  } kbd_item_t;

  typedef struct {
    logic       key_is_down;
    logic [7:0] first_down_key;
    logic       any_down;
  } key_report_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_func = FUNC_QUERY;
  logic [7:0] in_scan_code = '0;
  logic [7:0] in_query_key = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_key_is_down;
  logic [7:0] out_first_down_key;
  logic       out_any_down;

  kbd_item_t   pending_items[$];
  key_report_t expected_reports[$];
  kbd_item_t   driven_item;
  int unsigned items_queued;
  int unsigned error_count;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned idle_cycles;
  bit          calm_phase;

  // Shadow of the tracker state
  bit [255:0] key_map_shadow;
  bit         prefix_armed;

  keyboard_scan_code_key_tracker DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_scan_code       (in_scan_code),
    .in_query_key       (in_query_key),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_key_is_down    (out_key_is_down),
    .out_first_down_key (out_first_down_key),
    .out_any_down       (out_any_down)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_named_key(int unsigned k);
    return (k >= 8'h01 && k <= 8'h54) || (k >= 8'h56 && k <= 8'h58) ||
           k == 8'h9C || k == 8'h9D || k == 8'hB5 || k == 8'hB7 || k == 8'hB8 ||
           (k >= 8'hC7 && k <= 8'hC9) || k == 8'hCB || k == 8'hCD ||
           (k >= 8'hCF && k <= 8'hD3);
  endfunction

  // Update the shadow key map for one accepted item and queue the report it gives
  function automatic void track_key_event(kbd_item_t item);
    key_report_t rep;
    logic [7:0]  idx;
    logic [7:0]  first;
    first = '0;
    if (item.func == FUNC_SCAN) begin
      if (item.scan_code == PREFIX_BYTE) begin
        prefix_armed = 1'b1;
      end else begin
        idx = {prefix_armed, item.scan_code[6:0]};
        key_map_shadow[idx] = ~item.scan_code[7];
        prefix_armed = 1'b0;
      end
    end else if (item.func == FUNC_CLEAR) begin
      key_map_shadow = '0;
    end
    for (int i = 0; i < 256; i++) begin
      if (key_map_shadow[i] && is_named_key(i)) begin
        first = i[7:0];
        break;
      end
    end
    rep.key_is_down = key_map_shadow[item.query_key];
    rep.first_down_key = first;
    rep.any_down = (first != 8'h00);
    expected_reports.push_back(rep);
  endfunction

  function automatic void note_error(string what, logic [7:0] want, logic [7:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  task automatic add_item(logic [1:0] f, logic [7:0] code, logic [7:0] query);
    kbd_item_t item;
    item.func = f;
    item.scan_code = code;
    item.query_key = query;
    // two forced drains in mid-run, and a calm tail with no idling
    item.wait_drain = (items_queued == 260 || items_queued == 570);
    item.calm = (items_queued >= 740);
    pending_items.push_back(item);
    items_queued++;
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        track_key_event(driven_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_items[0].wait_drain && expected_reports.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!pending_items[0].calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          driven_item = pending_items.pop_front();
          calm_phase = driven_item.calm;
          in_valid <= 1'b1;
          in_func <= driven_item.func;
          in_scan_code <= driven_item.scan_code;
          in_query_key <= driven_item.query_key;
        end
      end
    end
  end

  // Monitor and result-side back-pressure
  always @(posedge clk) begin
    key_report_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          note_error("unexpected transaction", 8'h00, out_first_down_key);
        end else begin
          want = expected_reports.pop_front();
          if (out_key_is_down !== want.key_is_down)
            note_error("key_is_down", {7'b0, want.key_is_down}, {7'b0, out_key_is_down});
          if (out_first_down_key !== want.first_down_key)
            note_error("first_down_key", want.first_down_key, out_first_down_key);
          if (out_any_down !== want.any_down)
            note_error("any_down", {7'b0, want.any_down}, {7'b0, out_any_down});
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] held[$];
    logic [7:0] key;
    logic [7:0] code;
    int unsigned pick;
    int unsigned slot;
    bit ext;

    items_queued = 0;
    error_count = 0;
    gap_left = 0;
    stall_left = 0;
    idle_cycles = 0;
    calm_phase = 1'b0;
    key_map_shadow = '0;
    prefix_armed = 1'b0;

    // Directed part
    add_item(FUNC_QUERY, 8'h00, 8'h00);
    add_item(FUNC_QUERY, 8'hFF, 8'hFF);
    add_item(FUNC_SCAN, 8'h00, 8'h00);       // unnamed key 0 down
    add_item(FUNC_SCAN, 8'h01, 8'h01);       // lowest named key
    add_item(FUNC_SCAN, PREFIX_BYTE, 8'h9C);
    add_item(FUNC_SCAN, 8'h1C, 8'h9C);       // extended key 0x9C
    add_item(FUNC_SCAN, 8'h81, 8'h01);       // break of key 1
    add_item(FUNC_SCAN, PREFIX_BYTE, 8'hD3);
    add_item(FUNC_SCAN, PREFIX_BYTE, 8'hD3); // prefix armed twice
    add_item(FUNC_SCAN, 8'h53, 8'hD3);
    add_item(FUNC_SCAN, 8'h7F, 8'h7F);
    add_item(FUNC_SCAN, 8'h55, 8'h55);       // unnamed, tracked only
    add_item(FUNC_SCAN, PREFIX_BYTE, 8'hFF);
    add_item(FUNC_SCAN, 8'h7F, 8'hFF);
    add_item(FUNC_SPARE, 8'h01, 8'h01);      // spare selector, no change
    add_item(FUNC_QUERY, 8'h81, 8'hD3);      // scan byte ignored
    add_item(FUNC_SCAN, 8'h9C, 8'h9C);       // break of plain 0x1C
    add_item(FUNC_SCAN, PREFIX_BYTE, 8'hB8);
    add_item(FUNC_CLEAR, 8'h00, 8'hFF);      // prefix survives the clear
    add_item(FUNC_SCAN, 8'h38, 8'hB8);
    add_item(FUNC_SCAN, 8'h58, 8'h58);
    add_item(FUNC_SCAN, 8'hB8, 8'hB8);
    add_item(FUNC_SCAN, PREFIX_BYTE, 8'hB8);
    add_item(FUNC_SCAN, 8'hB8, 8'hB8);
    add_item(FUNC_CLEAR, 8'hFF, 8'h58);

    // Random part: mostly make/break sequences with noise mixed in
    while (items_queued < RANDOM_ITEMS + 25) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        if (held.size() != 0 && ($urandom_range(0, 99) < 45 || held.size() > 12)) begin
          slot = $urandom_range(0, held.size() - 1);
          key = held[slot];
          held.delete(slot);
          code = {1'b1, key[6:0]};
        end else begin
          ext = ($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 99) < 65)
            code = 8'($urandom_range(1, 8'h58));
          else
            code = 8'($urandom_range(0, 127));
          key = {ext, code[6:0]};
          held.push_back(key);
        end
        if (key[7])
          add_item(FUNC_SCAN, PREFIX_BYTE, 8'($urandom_range(0, 255)));
        add_item(FUNC_SCAN, code,
                 ($urandom_range(0, 1) != 0) ? key : 8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        add_item(FUNC_QUERY, 8'($urandom_range(0, 255)),
                 (held.size() != 0 && $urandom_range(0, 1) != 0) ? held[0] :
                 8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        add_item(FUNC_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        held.delete();
      end else if (pick < 91) begin
        add_item(FUNC_SPARE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        add_item(FUNC_SCAN, PREFIX_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        add_item(FUNC_SCAN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_reports.size() != 0)
      note_error("missing transaction", 8'h00, 8'h00);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/kst_pkg.sv
hw/rtl/kst_ctrl.sv
hw/rtl/kst_datapath.sv
hw/rtl/keyboard_scan_code_key_tracker.sv
hw/rtl/kst_checker.sv
sim/testbench.sv
